FILE: sv/pgp_pkg.sv
// shared types and constants for the particle global position core
// no dependencies
package pgp_pkg;

  localparam int DOMAIN_COUNT = 2048;
  localparam int DOMAIN_W     = 11;
  localparam int FIELD_W      = 4;
  localparam int WORDS        = 9;
  localparam int FRAC_BITS    = 16;
  localparam int WORD_W       = 32;
  localparam int OFF_W        = 16;
  localparam int DIV_W        = 32;
  localparam int IN_DATA_W    = 128;
  localparam int OUT_DATA_W   = 96;

  // table word codes
  localparam logic [FIELD_W-1:0] FLD_NX = 4'd0;
  localparam logic [FIELD_W-1:0] FLD_NY = 4'd1;
  localparam logic [FIELD_W-1:0] FLD_NZ = 4'd2;
  localparam logic [FIELD_W-1:0] FLD_DX = 4'd3;
  localparam logic [FIELD_W-1:0] FLD_X0 = 4'd6;

  localparam logic OP_COMPUTE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  // sideband that rides along the divider pipeline
  typedef struct packed {
    logic                    valid;
    logic [2:0][OFF_W-1:0]   off;
    logic [2:0][WORD_W-1:0]  size;
    logic [2:0][WORD_W-1:0]  origin;
    logic [DIV_W-1:0]        wy;
    logic [DIV_W-1:0]        ix;
  } side_t;

endpackage

FILE: sv/pgp_divider.sv
// fully pipelined unsigned restoring divider, one quotient bit per stage
// depends on pgp_pkg
module pgp_divider (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    en,
  input  logic [pgp_pkg::DIV_W-1:0] dividend,
  input  logic [pgp_pkg::DIV_W-1:0] divisor,
  input  pgp_pkg::side_t          side_in,
  output logic [pgp_pkg::DIV_W-1:0] quo,
  output logic [pgp_pkg::DIV_W-1:0] rem,
  output pgp_pkg::side_t          side_out
);

  localparam int W = pgp_pkg::DIV_W;

  logic [W-1:0]   q_r [W];
  logic [W-1:0]   r_r [W];
  logic [W-1:0]   d_r [W];
  pgp_pkg::side_t s_r [W];

  for (genvar j = 0; j < W; j++) begin : g_st
    logic [W-1:0]   q_in;
    logic [W-1:0]   r_in;
    logic [W-1:0]   d_in;
    pgp_pkg::side_t s_in;
    logic [W:0]     t;
    logic           take;

    if (j == 0) begin : g_first
      assign q_in = dividend;
      assign r_in = '0;
      assign d_in = divisor;
      assign s_in = side_in;
    end else begin : g_next
      assign q_in = q_r[j-1];
      assign r_in = r_r[j-1];
      assign d_in = d_r[j-1];
      assign s_in = s_r[j-1];
    end

    // shift in the next dividend bit, subtract when it fits
    assign t    = {r_in, q_in[W-1]};
    assign take = t >= {1'b0, d_in};

    always_ff @(posedge clk) begin
      if (rst) begin
        s_r[j].valid <= 1'b0;
      end else if (en) begin
        s_r[j] <= s_in;
      end
      if (en) begin
        r_r[j] <= take ? W'(t - {1'b0, d_in}) : t[W-1:0];
        q_r[j] <= {q_in[W-2:0], take};
        d_r[j] <= d_in;
      end
    end
  end

  assign quo      = q_r[W-1];
  assign rem      = r_r[W-1];
  assign side_out = s_r[W-1];

endmodule

FILE: sv/particle_global_position_core.sv
// particle global position core: voxel index plus in-cell offsets to global x, y, z
// depends on pgp_pkg and pgp_divider
//
// A request with tuser = 1 writes one word of the per-domain table (nine words per
// domain: counts nx, ny, nz, cell sizes, origins) and gives no result. A request with
// tuser = 0 reads the row of its domain, splits the linear voxel index by nx+2 and
// ny+2 (a count below -1 gives a divisor of one), and returns, per axis,
// (index + (offset-1)/2) * size + origin in Q16.16, floored and saturated. A compute
// request must only use table words written before it. The block takes one request
// every cycle while the output is not stalled; the result is offered from
// 67 register stages, of which the first loads at acceptance:
// one table-read stage, two 32-stage pipelined dividers (one quotient bit per
// stage), one multiply stage and one add/saturate stage that is also the output
// register. A stall on the output freezes the whole pipeline, so nothing is lost.
module particle_global_position_core (
  input  logic                             clk,
  input  logic                             rst,
  // request side
  input  logic                             s_tvalid,
  output logic                             s_tready,
  // domain[10:0], table_field[14:11], table_value[46:15], cell_index[78:47],
  // offset_x[94:79], offset_y[110:95], offset_z[126:111], zero pad [127]
  input  logic [pgp_pkg::IN_DATA_W-1:0]    s_tdata,
  // op[0]
  input  logic                             s_tuser,
  // result side
  output logic                             m_tvalid,
  input  logic                             m_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64]
  output logic [pgp_pkg::OUT_DATA_W-1:0]   m_tdata
);

  localparam int W = pgp_pkg::WORD_W;
  localparam int F = pgp_pkg::FRAC_BITS;

  // global advance: whole pipeline moves unless the output is stuck
  logic adv;
  assign adv      = !m_tvalid || m_tready;
  assign s_tready = adv;

  // request fields
  logic [pgp_pkg::DOMAIN_W-1:0] domain;
  logic [pgp_pkg::FIELD_W-1:0]  table_field;
  logic [W-1:0]                 table_value;
  logic [W-1:0]                 cell_index;
  logic [2:0][pgp_pkg::OFF_W-1:0] offs;
  logic                         accept;

  assign domain      = s_tdata[10:0];
  assign table_field = s_tdata[14:11];
  assign table_value = s_tdata[46:15];
  assign cell_index  = s_tdata[78:47];
  assign offs        = s_tdata[126:79];
  assign accept      = s_tvalid && adv;

  // domain table: one memory per word so the whole row reads at once
  logic [W-1:0] rd [pgp_pkg::WORDS];

  for (genvar k = 0; k < pgp_pkg::WORDS; k++) begin : g_tbl
    logic [W-1:0] mem [pgp_pkg::DOMAIN_COUNT];

    always_ff @(posedge clk) begin
      if (accept && s_tuser == pgp_pkg::OP_WRITE &&
          table_field == pgp_pkg::FIELD_W'(k)) begin
        mem[domain] <= table_value;
      end
      if (adv) begin
        rd[k] <= mem[domain];
      end
    end
  end

  // stage 1: table read, request payload held alongside
  logic                           s1_valid;
  logic [W-1:0]                   s1_cell;
  logic [2:0][pgp_pkg::OFF_W-1:0] s1_off;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= accept && s_tuser == pgp_pkg::OP_COMPUTE;
    end
    if (adv) begin
      s1_cell <= cell_index;
      s1_off  <= offs;
    end
  end

  // divisors nx+2 and ny+2, clamped to at least one
  function automatic logic [W-1:0] divisor_of(input logic [W-1:0] n);
    logic signed [W:0] d;
    d = $signed({n[W-1], n}) + $signed((W+1)'(2));
    return (d < $signed((W+1)'(1))) ? W'(1) : d[W-1:0];
  endfunction

  pgp_pkg::side_t side1;
  logic [W-1:0]   wx;

  assign wx = divisor_of(rd[pgp_pkg::FLD_NX]);

  always_comb begin
    side1.valid = s1_valid;
    side1.off   = s1_off;
    for (int k = 0; k < 3; k++) begin
      side1.size[k]   = rd[int'(pgp_pkg::FLD_DX) + k];
      side1.origin[k] = rd[int'(pgp_pkg::FLD_X0) + k];
    end
    side1.wy = divisor_of(rd[pgp_pkg::FLD_NY]);
    side1.ix = '0;
  end

  // first divider: cell / wx gives ix as remainder
  logic [W-1:0]   q1;
  logic [W-1:0]   r1;
  pgp_pkg::side_t side2_raw;
  pgp_pkg::side_t side2;

  pgp_divider u_div_x (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .dividend (s1_cell),
    .divisor  (wx),
    .side_in  (side1),
    .quo      (q1),
    .rem      (r1),
    .side_out (side2_raw)
  );

  always_comb begin
    side2    = side2_raw;
    side2.ix = r1;
  end

  // second divider: (cell / wx) / wy gives iz, remainder iy
  logic [W-1:0]   iz;
  logic [W-1:0]   iy;
  pgp_pkg::side_t side3;

  pgp_divider u_div_y (
    .clk      (clk),
    .rst      (rst),
    .en       (adv),
    .dividend (q1),
    .divisor  (side2.wy),
    .side_in  (side2),
    .quo      (iz),
    .rem      (iy),
    .side_out (side3)
  );

  logic [2:0][W-1:0] idx;
  assign idx[0] = side3.ix;
  assign idx[1] = iy;
  assign idx[2] = iz;

  // stage A: whole-cell and in-cell products per axis
  logic                     a_valid;
  logic signed [2*W:0]      a_whole  [3];
  logic signed [W+16:0]     a_part   [3];
  logic signed [W-1:0]      a_origin [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= side3.valid;
    end
    if (adv) begin
      for (int k = 0; k < 3; k++) begin
        // coordinate = (index-1)*2^16 + (offset + 2^15)
        a_whole[k]  <= ($signed({1'b0, idx[k]}) - $signed((W+1)'(1))) *
                       $signed(side3.size[k]);
        a_part[k]   <= $signed({1'b0, ~side3.off[k][15], side3.off[k][14:0]}) *
                       $signed(side3.size[k]);
        a_origin[k] <= $signed(side3.origin[k]);
      end
    end
  end

  // stage B: clamp, floor, add origin, saturate; this is the output register
  localparam logic signed [42:0] MID_HI = 43'sd1 <<< 40;
  localparam logic signed [42:0] MID_LO = -(43'sd1 <<< 40);
  localparam logic signed [42:0] SAT_HI = 43'sd2147483647;
  localparam logic signed [42:0] SAT_LO = -43'sd2147483648;

  logic [2:0][W-1:0] pos_next;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      logic signed [42:0] wc;
      logic signed [42:0] sum;
      wc = (a_whole[k] > 65'(MID_HI)) ? MID_HI :
           (a_whole[k] < 65'(MID_LO)) ? MID_LO : a_whole[k][42:0];
      sum = wc + 43'(a_part[k] >>> F) + 43'(a_origin[k]);
      pos_next[k] = (sum > SAT_HI) ? W'(SAT_HI) :
                    (sum < SAT_LO) ? W'(SAT_LO) : sum[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (adv) begin
      m_tvalid <= a_valid;
    end
    if (adv) begin
      m_tdata <= pos_next;
    end
  end

  // checks
  a_reset_clear: assert property (@(posedge clk) rst |=> !m_tvalid && !s1_valid)
    else $error("pipeline valid not cleared by reset");
  a_write_no_result: assert property (@(posedge clk) disable iff (rst)
    accept && s_tuser == pgp_pkg::OP_WRITE |=> !s1_valid)
    else $error("table write entered the compute pipeline");
  a_stall_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(s1_valid) && $stable(a_valid))
    else $error("pipeline moved during stall");

endmodule

FILE: tb/testbench.sv
// self-checking testbench for particle_global_position_core
// depends on pgp_pkg and the core rtl; writes table rows, streams compute requests and
// checks every position against a built-in predictor of the fixed-point math
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 100;
  localparam int RANDOM_ITEMS = 1950;

  typedef struct {
    logic        op;
    logic [10:0] domain;
    logic [3:0]  field;
    logic [31:0] value;
    logic [31:0] voxel;
    logic [15:0] ox, oy, oz;
    bit          typed;
    logic [31:0] ex, ey, ez;
  } stim_row_t;

  typedef struct {
    logic [31:0] px, py, pz;
  } position_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [pgp_pkg::IN_DATA_W-1:0] s_tdata = '0;
  logic s_tuser = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [pgp_pkg::OUT_DATA_W-1:0] m_tdata;

  logic [31:0] domain_words [0:pgp_pkg::DOMAIN_COUNT*pgp_pkg::WORDS-1];
  bit          row_ready [0:pgp_pkg::DOMAIN_COUNT-1];
  position_t   pending_positions [$];
  int          errors = 0;
  int          cycles = 0;
  bit          send_quiet = 1'b0;
  bit          recv_quiet = 1'b0;

  particle_global_position_core u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // one axis: (index + (offset-1)/2) * size + origin, floored and saturated
  function automatic logic [31:0] axis_position(longint unsigned idx, logic signed [15:0] off,
                                                logic signed [31:0] size,
                                                logic signed [31:0] origin);
    logic signed [97:0] h98, s98, whole, lim;
    longint hi, lo, part, sum;
    hi = longint'(idx) - 1;
    h98 = hi;
    s98 = size;
    whole = h98 * s98;
    lim = 1;
    lim = lim <<< 40;
    if (whole > lim) whole = lim;
    if (whole < -lim) whole = -lim;
    lo = longint'(off) + 32768;
    part = (lo * longint'(size)) >>> 16;
    sum = longint'(whole) + part + longint'(origin);
    if (sum > 64'sd2147483647) sum = 64'sd2147483647;
    if (sum < -64'sd2147483648) sum = -64'sd2147483648;
    return sum[31:0];
  endfunction

  // a count below -1 divides by one
  function automatic longint unsigned cell_divisor(logic signed [31:0] count);
    longint d;
    d = longint'(count) + 2;
    return (d < 1) ? 1 : longint'(d);
  endfunction

  function automatic position_t predict_position(logic [10:0] dom, logic [31:0] voxel,
                                                 logic [15:0] ox, logic [15:0] oy,
                                                 logic [15:0] oz);
    int base;
    longint unsigned wx, wy, c;
    position_t p;
    base = dom * pgp_pkg::WORDS;
    wx = cell_divisor(domain_words[base + pgp_pkg::FLD_NX]);
    wy = cell_divisor(domain_words[base + pgp_pkg::FLD_NY]);
    c = voxel;
    p.px = axis_position(c % wx, ox, domain_words[base + pgp_pkg::FLD_DX],
                         domain_words[base + pgp_pkg::FLD_X0]);
    p.py = axis_position((c / wx) % wy, oy, domain_words[base + pgp_pkg::FLD_DX + 1],
                         domain_words[base + pgp_pkg::FLD_X0 + 1]);
    p.pz = axis_position(c / (wx * wy), oz, domain_words[base + pgp_pkg::FLD_DX + 2],
                         domain_words[base + pgp_pkg::FLD_X0 + 2]);
    return p;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %h expected %h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  // drive one request at the falling edge, hold until accepted, then update the predictor
  task automatic send_request(stim_row_t r);
    position_t p;
    @(negedge clk);
    while (!send_quiet && $urandom_range(99) < 14) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tuser = r.op;
    s_tdata = {1'b0, r.oz, r.oy, r.ox, r.voxel, r.value, r.field, r.domain};
    do @(posedge clk); while (!s_tready);
    if (r.op == pgp_pkg::OP_WRITE) begin
      if (r.field < pgp_pkg::WORDS)
        domain_words[r.domain * pgp_pkg::WORDS + r.field] = r.value;
    end else begin
      p = predict_position(r.domain, r.voxel, r.ox, r.oy, r.oz);
      if (r.typed && (p.px !== r.ex || p.py !== r.ey || p.pz !== r.ez))
        $display("note: predictor disagrees with typed row at cycle %0d", cycles);
      if (r.typed) begin
        p.px = r.ex;
        p.py = r.ey;
        p.pz = r.ez;
      end
      pending_positions.push_back(p);
    end
  endtask

  function automatic stim_row_t make_write(logic [10:0] dom, logic [3:0] fld, logic [31:0] v);
    stim_row_t r;
    r = '{default: '0};
    r.op = pgp_pkg::OP_WRITE;
    r.domain = dom;
    r.field = fld;
    r.value = v;
    r.voxel = $urandom;
    r.ox = 16'($urandom);
    r.oy = 16'($urandom);
    r.oz = 16'($urandom);
    return r;
  endfunction

  function automatic stim_row_t make_compute(logic [10:0] dom, logic [31:0] voxel,
                                             logic [15:0] ox, logic [15:0] oy, logic [15:0] oz);
    stim_row_t r;
    r = '{default: '0};
    r.op = pgp_pkg::OP_COMPUTE;
    r.domain = dom;
    r.field = 4'($urandom);
    r.value = $urandom;
    r.voxel = voxel;
    r.ox = ox;
    r.oy = oy;
    r.oz = oz;
    return r;
  endfunction

  function automatic stim_row_t typed_compute(logic [10:0] dom, logic [15:0] off,
                                              logic [31:0] want);
    stim_row_t r;
    r = make_compute(dom, 32'd0, off, off, off);
    r.typed = 1'b1;
    r.ex = want;
    r.ey = want;
    r.ez = want;
    return r;
  endfunction

  // count: mostly small, sometimes any value, including ones below -1
  function automatic logic [31:0] random_count();
    case ($urandom_range(9))
      0: return $urandom;
      1: return -$urandom_range(5);
      default: return $urandom_range(20);
    endcase
  endfunction

  task automatic write_row(logic [10:0] dom);
    logic [31:0] v;
    for (int f = 0; f < pgp_pkg::WORDS; f++) begin
      if (f < 3) v = random_count();
      else if ($urandom_range(3) == 0) v = $urandom;
      else v = $urandom_range(32'h0004_0000) - 32'h0002_0000;
      send_request(make_write(dom, f[3:0], v));
    end
    row_ready[dom] = 1'b1;
  endtask

  // output side: random stalls, compare against the oldest expected position
  initial begin
    forever begin
      @(negedge clk);
      m_tready = recv_quiet || ($urandom_range(99) >= 14);
    end
  end

  always @(posedge clk) begin
    position_t w;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_positions.size() == 0) begin
        $display("unexpected result %h at cycle %0d", m_tdata, cycles);
        errors++;
      end else begin
        w = pending_positions.pop_front();
        if (m_tdata[31:0] !== w.px) report_mismatch("pos_x", m_tdata[31:0], w.px);
        if (m_tdata[63:32] !== w.py) report_mismatch("pos_y", m_tdata[63:32], w.py);
        if (m_tdata[95:64] !== w.pz) report_mismatch("pos_z", m_tdata[95:64], w.pz);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("timeout at cycle %0d", cycles);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    stim_row_t directed [$];
    stim_row_t r;
    logic [10:0] dom;
    int sent;
    int k;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // domain 5: unit cells, zero origin, so cell 0 sits at -0.5 cell per axis
    for (int f = 0; f < 3; f++) directed.push_back(make_write(11'd5, f[3:0], 32'd0));
    for (int f = 3; f < 6; f++) directed.push_back(make_write(11'd5, f[3:0], 32'h0001_0000));
    for (int f = 6; f < 9; f++) directed.push_back(make_write(11'd5, f[3:0], 32'd0));
    // fields above eight are dropped
    directed.push_back(make_write(11'd5, 4'd9, 32'hFFFF_FFFF));
    directed.push_back(make_write(11'd5, 4'd15, 32'h8000_0000));
    directed.push_back(typed_compute(11'd5, 16'h0000, 32'hFFFF_8000));
    directed.push_back(typed_compute(11'd5, 16'h8000, 32'hFFFF_0000)); // offset of exactly -1
    directed.push_back(typed_compute(11'd5, 16'h7FFF, 32'hFFFF_FFFF));
    directed.push_back(make_compute(11'd5, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h0001));
    // top domain: small count, huge count, extreme sizes and origins to saturate
    directed.push_back(make_write(11'd2047, pgp_pkg::FLD_NX, 32'hFFFF_FFFB));
    directed.push_back(make_write(11'd2047, pgp_pkg::FLD_NY, 32'h7FFF_FFFF));
    directed.push_back(make_write(11'd2047, pgp_pkg::FLD_NZ, 32'h8000_0000));
    directed.push_back(make_write(11'd2047, 4'd3, 32'h7FFF_FFFF));
    directed.push_back(make_write(11'd2047, 4'd4, 32'h8000_0000));
    directed.push_back(make_write(11'd2047, 4'd5, 32'h7FFF_FFFF));
    directed.push_back(make_write(11'd2047, 4'd6, 32'h7FFF_FFFF));
    directed.push_back(make_write(11'd2047, 4'd7, 32'h8000_0000));
    directed.push_back(make_write(11'd2047, 4'd8, 32'h8000_0000));
    directed.push_back(make_compute(11'd2047, 32'hFFFF_FFFF, 16'h7FFF, 16'h8000, 16'h8000));
    directed.push_back(make_compute(11'd2047, 32'd0, 16'h0000, 16'h7FFF, 16'h0000));
    foreach (directed[i]) send_request(directed[i]);
    row_ready[5] = 1'b1;
    row_ready[2047] = 1'b1;

    // hold off until the pipeline has drained completely
    @(negedge clk);
    s_tvalid = 1'b0;
    while (pending_positions.size() != 0) @(negedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      send_quiet = (sent >= 700 && sent < 1000);
      recv_quiet = (sent >= 800 && sent < 1100);
      k = $urandom_range(99);
      if (k < 6) begin
        dom = 11'($urandom);
        write_row(dom);
        sent += pgp_pkg::WORDS;
      end else if (k < 9) begin
        // stray single write to a row already complete, any field code
        do dom = 11'($urandom); while (!row_ready[dom]);
        r = make_write(dom, 4'($urandom), $urandom);
        if (r.field < pgp_pkg::WORDS && r.field < 3) r.value = random_count();
        send_request(r);
        if (r.field < pgp_pkg::WORDS) sent++;
      end else begin
        do dom = 11'($urandom); while (!row_ready[dom]);
        r = make_compute(dom, ($urandom_range(3) == 0) ? $urandom : $urandom_range(4000),
                         16'($urandom), 16'($urandom), 16'($urandom));
        send_request(r);
        sent++;
      end
    end
    @(negedge clk);
    s_tvalid = 1'b0;
    send_quiet = 1'b0;
    recv_quiet = 1'b0;
    while (pending_positions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

FILE: files.f
sv/pgp_pkg.sv
sv/pgp_divider.sv
sv/particle_global_position_core.sv
tb/testbench.sv
